// ===== hw/rtl/tdps_pkg.sv =====
package tdps_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_DIRECT   = 3'd0;
   localparam logic [2:0] CSR_INDIRECT = 3'd1;
   localparam logic [2:0] CSR_LOWER    = 3'd2;
   localparam logic [2:0] CSR_UPPER    = 3'd3;
   localparam logic [2:0] CSR_OFFSET   = 3'd4;
   localparam logic [2:0] CSR_GAIN     = 3'd5;

   localparam logic [15:0] LOWER_RESET = 16'd28815;
   localparam logic [15:0] UPPER_RESET = 16'd30315;
   localparam logic [31:0] GAIN_RESET  = 32'd65536;

   localparam int RANGE_FRAC_BITS_DEF = 16;

   // Luma weights out of 16384 (red and blue swapped upstream)
   localparam logic [13:0] GRAY_R_WT = 14'd1868;
   localparam logic [13:0] GRAY_G_WT = 14'd9617;
   localparam logic [13:0] GRAY_B_WT = 14'd4899;

   // 255 * 255, the common denominator of the heat sum
   localparam logic [15:0] HEAT_SCALE = 16'd65025;

   localparam int REM_W = 45;
   localparam int DEN_W = 33;
   localparam int QUO_W = 9;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             sat;
      logic             zero;
      logic             eqm;
      logic             eqhi;
      logic [15:0]      range;
   } div_type;

   function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [22:0] s;
      s = 23'(r) * 23'(GRAY_R_WT) + 23'(g) * 23'(GRAY_G_WT) + 23'(b) * 23'(GRAY_B_WT)
          + 23'd8192;
      return s[21:14];
   endfunction

endpackage

// ===== hw/rtl/tdps_div_stage.sv =====
module tdps_div_stage
   import tdps_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             load,
   input  logic [DEN_W-1:0] den,
   input  div_type          stage_in,
   output div_type          stage_out
);

   div_type              stage_ff;
   div_type              stage_in_w;
   logic [REM_W-1:0]     trial;

   // Compare and subtract one shifted divisor, set one quotient bit
   always_comb begin
      trial      = REM_W'(den) << SHIFT;
      stage_in_w = stage_in;
      if (stage_in.rem >= trial) begin
         stage_in_w.rem        = stage_in.rem - trial;
         stage_in_w.quo[SHIFT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in_w;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== hw/rtl/thermal_depth_pixel_synthesis.sv =====
// Thermal and depth pixel synthesis.
// Request channel (req_*): one pixel per request, lit and unlit color samples,
// a raw thermal count and a Q16.16 depth. Response channel (rsp_*): one
// normalized heat level and one 16-bit depth per request, in request order.
// Both channels move a request when valid is high and stall is low.
// Configuration (csr_*): write-only registers, written while no request is in
// flight; unknown indexes are dropped.
// Throughput: one request per cycle while nothing stalls; each of the 16 pipeline
// stages holds one pixel, and the heat division resolves one quotient bit per stage.
// When the receiver stalls, the last stage holds; earlier stages keep filling
// empty slots, and req_stall rises only once every stage is occupied.
// Reset empties the pipeline and loads the default registers: limits
// 28815 and 30315 centikelvin, unity depth gain, zero offset and factors.
module thermal_depth_pixel_synthesis
   import tdps_pkg::*;
#(
   parameter int RANGE_FRAC_BITS = RANGE_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_lit_red,
   input  logic [7:0]  req_lit_green,
   input  logic [7:0]  req_lit_blue,
   input  logic [7:0]  req_unlit_red,
   input  logic [7:0]  req_unlit_green,
   input  logic [7:0]  req_unlit_blue,
   input  logic [15:0] req_heat_raw,
   input  logic [31:0] req_range_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_heat_level,
   output logic [15:0] rsp_range_out,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int NS  = 16;
   localparam int NDS = 7;
   localparam int SW  = ((32 + RANGE_FRAC_BITS > 48) ? 32 + RANGE_FRAC_BITS : 48) + 2;
   localparam int SHW = SW - 33;
   localparam int HW  = SHW + 33;

   // Configuration registers
   logic signed [15:0] direct_ff, indirect_ff;
   logic [15:0]        lower_ff, upper_ff;
   logic signed [31:0] offset_ff;
   logic [31:0]        gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direct_ff   <= '0;
         indirect_ff <= '0;
         lower_ff    <= LOWER_RESET;
         upper_ff    <= UPPER_RESET;
         offset_ff   <= '0;
         gain_ff     <= GAIN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DIRECT:   direct_ff   <= signed'(csr_wdata[15:0]);
            CSR_INDIRECT: indirect_ff <= signed'(csr_wdata[15:0]);
            CSR_LOWER:    lower_ff    <= csr_wdata[15:0];
            CSR_UPPER:    upper_ff    <= csr_wdata[15:0];
            CSR_OFFSET:   offset_ff   <= signed'(csr_wdata);
            CSR_GAIN:     gain_ff     <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Stage control: a stage loads when empty or when its content moves on
   logic [NS-1:0] v_ff;
   logic [NS:0]   load;

   always_comb begin
      load[NS] = !rsp_stall;
      for (int i = NS - 1; i >= 0; i--) begin
         load[i] = !v_ff[i] || load[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (load[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (load[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = v_ff[NS-1];

   // Stage 1: gray levels and offset depth
   logic [7:0]           lit1_ff, dark1_ff;
   logic [15:0]          raw1_ff;
   logic signed [SW-1:0] s1_ff;
   logic signed [SW-1:0] range_ext, off_ext;

   assign range_ext = signed'(SW'({req_range_in, 16'h0000}));
   assign off_ext   = SW'(offset_ff) <<< RANGE_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (load[0]) begin
         lit1_ff  <= gray_of(req_lit_red, req_lit_green, req_lit_blue);
         dark1_ff <= gray_of(req_unlit_red, req_unlit_green, req_unlit_blue);
         raw1_ff  <= req_heat_raw;
         s1_ff    <= range_ext + off_ext;
      end
   end

   // Stage 2: shade products, scaled raw heat and partial depth products
   logic [7:0]         inv2;
   logic signed [8:0]  diff2;
   logic signed [17:0] ivd2_ff;
   logic [15:0]        iv255_2_ff;
   logic [31:0]        raw65_2_ff;
   logic [63:0]        lo2_ff;
   logic [SHW+31:0]    hi2_ff;
   logic               zero2_ff;

   assign inv2  = 8'd255 - dark1_ff;
   assign diff2 = signed'({1'b0, lit1_ff}) - signed'({1'b0, dark1_ff});

   always_ff @(posedge clock) begin
      if (load[1]) begin
         ivd2_ff    <= signed'({1'b0, inv2}) * diff2;
         iv255_2_ff <= inv2 * 8'd255;
         raw65_2_ff <= raw1_ff * HEAT_SCALE;
         lo2_ff     <= s1_ff[31:0] * gain_ff;
         hi2_ff     <= s1_ff[SW-2:32] * gain_ff;
         zero2_ff   <= s1_ff[SW-1] || (s1_ff == '0);
      end
   end

   // Stage 3: factor products and depth high word
   logic signed [33:0] dterm3_ff;
   logic signed [32:0] iterm3_ff;
   logic [31:0]        raw65_3_ff;
   logic [HW-1:0]      hsum3_ff;
   logic               zero3_ff;

   always_ff @(posedge clock) begin
      if (load[2]) begin
         dterm3_ff  <= direct_ff * ivd2_ff;
         iterm3_ff  <= indirect_ff * signed'({1'b0, iv255_2_ff});
         raw65_3_ff <= raw65_2_ff;
         hsum3_ff   <= HW'(hi2_ff) + HW'(lo2_ff[63:32]);
         zero3_ff   <= zero2_ff;
      end
   end

   // Stage 4: heat sum and depth round and saturate
   logic signed [35:0] num4_ff;
   logic [15:0]        range4_ff;
   logic [HW-1:0]      rnd4;

   assign rnd4 = (hsum3_ff + (HW'(1) << (RANGE_FRAC_BITS - 1))) >> RANGE_FRAC_BITS;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         num4_ff <= signed'({4'b0000, raw65_3_ff}) + 36'(dterm3_ff) + 36'(iterm3_ff);
         if (zero3_ff) begin
            range4_ff <= '0;
         end else if (rnd4 > HW'(16'hFFFF)) begin
            range4_ff <= 16'hFFFF;
         end else begin
            range4_ff <= rnd4[15:0];
         end
      end
   end

   // Stage 5: distance from the lower limit, sign folded into the numerator
   logic [31:0]        low5;
   logic signed [36:0] x5;
   logic signed [36:0] xadj5_ff;
   logic               eqm5_ff, eqhi5_ff;
   logic [15:0]        range5_ff;

   assign low5 = lower_ff * HEAT_SCALE;
   assign x5   = 37'(num4_ff) - signed'({5'b00000, low5});

   always_ff @(posedge clock) begin
      if (load[4]) begin
         xadj5_ff  <= (upper_ff < lower_ff) ? -x5 : x5;
         eqm5_ff   <= (upper_ff == lower_ff);
         eqhi5_ff  <= (37'(num4_ff) > signed'({5'b00000, low5}));
         range5_ff <= range4_ff;
      end
   end

   // Divisor from the limit span
   logic signed [16:0] dd;
   logic [16:0]        absdd;
   logic [31:0]        dconst;
   logic [DEN_W-1:0]   den2;

   assign dd     = signed'({1'b0, upper_ff}) - signed'({1'b0, lower_ff});
   assign absdd  = dd[16] ? 17'(-dd) : 17'(dd);
   assign dconst = absdd[15:0] * HEAT_SCALE;
   assign den2   = {dconst, 1'b0};

   // Stage 6: rounded dividend 510*x + d
   logic [REM_W-1:0] n6_ff;
   logic             zero6_ff, eqm6_ff, eqhi6_ff;
   logic [15:0]      range6_ff;
   logic [35:0]      x36;
   logic             pos6;

   assign x36  = xadj5_ff[35:0];
   assign pos6 = !xadj5_ff[36] && (xadj5_ff != '0);

   always_ff @(posedge clock) begin
      if (load[5]) begin
         n6_ff     <= REM_W'({x36, 9'b0}) - REM_W'({x36, 1'b0}) + REM_W'(dconst);
         zero6_ff  <= !pos6;
         eqm6_ff   <= eqm5_ff;
         eqhi6_ff  <= eqhi5_ff;
         range6_ff <= range5_ff;
      end
   end

   // Stage 7: flag quotients past the division range
   div_type dv_ff;

   always_ff @(posedge clock) begin
      if (load[6]) begin
         dv_ff.rem   <= n6_ff;
         dv_ff.quo   <= '0;
         dv_ff.sat   <= (n6_ff >= (REM_W'(den2) << QUO_W));
         dv_ff.zero  <= zero6_ff;
         dv_ff.eqm   <= eqm6_ff;
         dv_ff.eqhi  <= eqhi6_ff;
         dv_ff.range <= range6_ff;
      end
   end

   // Stages 8 to 16: one quotient bit per stage
   div_type dchain [0:QUO_W];
   assign dchain[0] = dv_ff;

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      tdps_div_stage #(
         .SHIFT (QUO_W - 1 - k)
      ) u_div (
         .clock     (clock),
         .load      (load[NDS+k]),
         .den       (den2),
         .stage_in  (dchain[k]),
         .stage_out (dchain[k+1])
      );
   end

   // Response
   div_type fin;
   assign fin = dchain[QUO_W];

   always_comb begin
      if (fin.eqm) begin
         rsp_heat_level = fin.eqhi ? 8'd255 : 8'd0;
      end else if (fin.zero) begin
         rsp_heat_level = 8'd0;
      end else if (fin.sat || fin.quo[QUO_W-1]) begin
         rsp_heat_level = 8'd255;
      end else begin
         rsp_heat_level = fin.quo[7:0];
      end
   end

   assign rsp_range_out = fin.range;

`ifndef SYNTHESIS
   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[0])
      else $error("accepted request did not enter the first stage");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      ((&v_ff) && rsp_stall) |-> req_stall)
      else $error("full pipeline took a request under response stall");

   a_equal_limits : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && fin.eqm) |-> (rsp_heat_level == 8'd0 || rsp_heat_level == 8'd255))
      else $error("equal limits gave an intermediate heat level");

   a_hold_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");
`endif

endmodule
